// ===== hw/rtl/srht_pkg.sv =====
`default_nettype none
package srht_pkg;

   // region code bits
   localparam int unsigned RC_LEFT_BIT  = 0;
   localparam int unsigned RC_RIGHT_BIT = 1;
   localparam int unsigned RC_UPPER_BIT = 2;
   localparam int unsigned RC_LOWER_BIT = 3;

   // csr register indexes
   localparam logic [1:0] CSR_RECT_LEFT   = 2'd0;
   localparam logic [1:0] CSR_RECT_TOP    = 2'd1;
   localparam logic [1:0] CSR_RECT_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_RECT_BOTTOM = 2'd3;

   localparam int unsigned NUM_EDGES = 4;
   localparam int unsigned PIPE_LATENCY = 4;

   typedef logic [3:0] region_type;

endpackage
`default_nettype wire

// ===== hw/rtl/segment_rectangle_hit_test_core.sv =====
`default_nettype none
// segment / rectangle hit test core
// request channel: start with req_start_x, req_start_y, req_end_x, req_end_y is
// taken at a rising edge where start is high and busy is low. busy is always low,
// so a new segment can be issued every cycle.
// result channel: rsp_valid strobes for one cycle with rsp_hit, rsp_start_region
// and rsp_end_region once the request has passed the four pipeline registers.
// results come out in request order, one per request, one per cycle at full rate.
// the edge crossing test is done without division: the crossing bounds are
// compared against the product |a*m| through multiplications by |d|, in a
// four stage pipeline (codes, bounds, multiply, compare).
// csr channel: csr_valid/csr_ready write csr_data to register csr_index
// (0 left, 1 top, 2 right, 3 bottom). csr_ready is always high. write only
// while no request is in flight.
// reset clears the pipeline valid bits and sets an empty rectangle.
// the receiver cannot stall: each result is shown for exactly one cycle.
module segment_rectangle_hit_test_core #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  signed [COORD_BITS-1:0] req_start_x,
   input  wire  signed [COORD_BITS-1:0] req_start_y,
   input  wire  signed [COORD_BITS-1:0] req_end_x,
   input  wire  signed [COORD_BITS-1:0] req_end_y,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [1:0]                   csr_index,
   input  wire  signed [COORD_BITS-1:0] csr_data,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output srht_pkg::region_type         rsp_start_region,
   output srht_pkg::region_type         rsp_end_region
);
   import srht_pkg::*;

   localparam int unsigned N = COORD_BITS;
   localparam int unsigned W = COORD_BITS + 1;

   logic signed [N-1:0] rect_left_ff, rect_top_ff, rect_right_ff, rect_bottom_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= {1'b0, {(N-1){1'b1}}};
         rect_top_ff    <= {1'b0, {(N-1){1'b1}}};
         rect_right_ff  <= {1'b1, {(N-1){1'b0}}};
         rect_bottom_ff <= {1'b1, {(N-1){1'b0}}};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RECT_LEFT:   rect_left_ff   <= csr_data;
            CSR_RECT_TOP:    rect_top_ff    <= csr_data;
            CSR_RECT_RIGHT:  rect_right_ff  <= csr_data;
            CSR_RECT_BOTTOM: rect_bottom_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ---------------- stage 1: region codes and differences
   logic signed [W-1:0] x1_w, y1_w, x2_w, y2_w, l_w, t_w, r_w, b_w;
   region_type c1_in, c2_in, c_all;
   logic early_in;
   logic [NUM_EDGES-1:0] flag_in;
   logic signed [W-1:0] a_in [NUM_EDGES];

   assign x1_w = {req_start_x[N-1], req_start_x};
   assign y1_w = {req_start_y[N-1], req_start_y};
   assign x2_w = {req_end_x[N-1], req_end_x};
   assign y2_w = {req_end_y[N-1], req_end_y};
   assign l_w  = {rect_left_ff[N-1], rect_left_ff};
   assign t_w  = {rect_top_ff[N-1], rect_top_ff};
   assign r_w  = {rect_right_ff[N-1], rect_right_ff};
   assign b_w  = {rect_bottom_ff[N-1], rect_bottom_ff};

   always_comb begin
      c1_in = '0;
      c2_in = '0;
      if (req_start_x < rect_left_ff) c1_in[RC_LEFT_BIT] = 1'b1;
      else if (req_start_x > rect_right_ff) c1_in[RC_RIGHT_BIT] = 1'b1;
      if (req_start_y < rect_top_ff) c1_in[RC_UPPER_BIT] = 1'b1;
      else if (req_start_y > rect_bottom_ff) c1_in[RC_LOWER_BIT] = 1'b1;
      if (req_end_x < rect_left_ff) c2_in[RC_LEFT_BIT] = 1'b1;
      else if (req_end_x > rect_right_ff) c2_in[RC_RIGHT_BIT] = 1'b1;
      if (req_end_y < rect_top_ff) c2_in[RC_UPPER_BIT] = 1'b1;
      else if (req_end_y > rect_bottom_ff) c2_in[RC_LOWER_BIT] = 1'b1;
      c_all = c1_in | c2_in;
      early_in = 1'b0;
      flag_in  = '0;
      if ((c1_in & c2_in) != '0) begin
         early_in = 1'b0;
      end else if (c1_in == '0 || c2_in == '0 ||
                   c_all == region_type'((1 << RC_LEFT_BIT) | (1 << RC_RIGHT_BIT)) ||
                   c_all == region_type'((1 << RC_UPPER_BIT) | (1 << RC_LOWER_BIT))) begin
         early_in = 1'b1;
      end else begin
         flag_in = c_all;
      end
      a_in[0] = l_w - x1_w;
      a_in[1] = r_w - x1_w;
      a_in[2] = t_w - y1_w;
      a_in[3] = b_w - y1_w;
   end

   logic s1_valid_ff;
   region_type s1_c1_ff, s1_c2_ff;
   logic s1_early_ff;
   logic [NUM_EDGES-1:0] s1_flag_ff;
   logic signed [W-1:0] s1_a_ff [NUM_EDGES];
   logic signed [W-1:0] s1_dx_ff, s1_dy_ff, s1_x1_ff, s1_y1_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else       s1_valid_ff <= start && !busy;
      s1_c1_ff    <= c1_in;
      s1_c2_ff    <= c2_in;
      s1_early_ff <= early_in;
      s1_flag_ff  <= flag_in;
      s1_a_ff     <= a_in;
      s1_dx_ff    <= x2_w - x1_w;
      s1_dy_ff    <= y2_w - y1_w;
      s1_x1_ff    <= x1_w;
      s1_y1_ff    <= y1_w;
   end

   // ---------------- stage 2: magnitudes and quotient bounds
   // crossing v = base +/- q, q = floor(|a*m| / |d|); need lq <= q <= uq
   logic [N-1:0] am_in [NUM_EDGES];
   logic [N-1:0] mm_in [NUM_EDGES];
   logic [N-1:0] dm_in [NUM_EDGES];
   logic [N-1:0] lm_in [NUM_EDGES];
   logic [N:0]   um1_in [NUM_EDGES];
   logic [NUM_EDGES-1:0] uok_in;

   for (genvar e = 0; e < NUM_EDGES; e++) begin : g_bound
      logic signed [W-1:0] m_s, d_s, base_s, lo_s, hi_s, lq, uq, ma, mb, mc;
      logic neg;
      always_comb begin
         if (e < 2) begin
            m_s = s1_dy_ff;
            d_s = s1_dx_ff;
            base_s = s1_y1_ff;
            lo_s = t_w;
            hi_s = b_w;
         end else begin
            m_s = s1_dx_ff;
            d_s = s1_dy_ff;
            base_s = s1_x1_ff;
            lo_s = l_w;
            hi_s = r_w;
         end
         neg = s1_a_ff[e][W-1] ^ m_s[W-1] ^ d_s[W-1];
         ma = s1_a_ff[e][W-1] ? -s1_a_ff[e] : s1_a_ff[e];
         mb = m_s[W-1] ? -m_s : m_s;
         mc = d_s[W-1] ? -d_s : d_s;
         am_in[e] = ma[N-1:0];
         mm_in[e] = mb[N-1:0];
         dm_in[e] = mc[N-1:0];
         lq = neg ? base_s - hi_s : lo_s - base_s;
         uq = neg ? base_s - lo_s : hi_s - base_s;
         lm_in[e] = (lq[W-1] || lq == '0) ? '0 : lq[N-1:0];
         uok_in[e] = !uq[W-1];
         um1_in[e] = {1'b0, uq[N-1:0]} + {{N{1'b0}}, 1'b1};
      end
   end

   logic s2_valid_ff;
   region_type s2_c1_ff, s2_c2_ff;
   logic s2_early_ff;
   logic [NUM_EDGES-1:0] s2_flag_ff, s2_uok_ff;
   logic [N-1:0] s2_am_ff [NUM_EDGES];
   logic [N-1:0] s2_mm_ff [NUM_EDGES];
   logic [N-1:0] s2_dm_ff [NUM_EDGES];
   logic [N-1:0] s2_lm_ff [NUM_EDGES];
   logic [N:0]   s2_um1_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      if (reset) s2_valid_ff <= 1'b0;
      else       s2_valid_ff <= s1_valid_ff;
      s2_c1_ff    <= s1_c1_ff;
      s2_c2_ff    <= s1_c2_ff;
      s2_early_ff <= s1_early_ff;
      s2_flag_ff  <= s1_flag_ff;
      s2_uok_ff   <= uok_in;
      s2_am_ff    <= am_in;
      s2_mm_ff    <= mm_in;
      s2_dm_ff    <= dm_in;
      s2_lm_ff    <= lm_in;
      s2_um1_ff   <= um1_in;
   end

   // ---------------- stage 3: products
   logic s3_valid_ff;
   region_type s3_c1_ff, s3_c2_ff;
   logic s3_early_ff;
   logic [NUM_EDGES-1:0] s3_flag_ff, s3_uok_ff;
   logic [2*N-1:0] s3_p_ff  [NUM_EDGES];
   logic [2*N-1:0] s3_ld_ff [NUM_EDGES];
   logic [2*N:0]   s3_ud_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      if (reset) s3_valid_ff <= 1'b0;
      else       s3_valid_ff <= s2_valid_ff;
      s3_c1_ff    <= s2_c1_ff;
      s3_c2_ff    <= s2_c2_ff;
      s3_early_ff <= s2_early_ff;
      s3_flag_ff  <= s2_flag_ff;
      s3_uok_ff   <= s2_uok_ff;
      for (int e = 0; e < NUM_EDGES; e++) begin
         s3_p_ff[e]  <= {{N{1'b0}}, s2_am_ff[e]} * {{N{1'b0}}, s2_mm_ff[e]};
         s3_ld_ff[e] <= {{N{1'b0}}, s2_lm_ff[e]} * {{N{1'b0}}, s2_dm_ff[e]};
         s3_ud_ff[e] <= {{N{1'b0}}, s2_um1_ff[e]} * {{(N+1){1'b0}}, s2_dm_ff[e]};
      end
   end

   // ---------------- stage 4: compare and combine
   logic [NUM_EDGES-1:0] pass_in;
   logic hit_in;

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         pass_in[e] = s3_flag_ff[e] && s3_uok_ff[e] &&
                      (s3_p_ff[e] >= s3_ld_ff[e]) &&
                      ({1'b0, s3_p_ff[e]} < s3_ud_ff[e]);
      end
      hit_in = s3_early_ff || (pass_in != '0);
   end

   logic rsp_valid_ff, rsp_hit_ff;
   region_type rsp_c1_ff, rsp_c2_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= s3_valid_ff;
      rsp_hit_ff <= hit_in;
      rsp_c1_ff  <= s3_c1_ff;
      rsp_c2_ff  <= s3_c2_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_start_region = rsp_c1_ff;
   assign rsp_end_region   = rsp_c2_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/srht_checker.sv =====
`default_nettype none
module srht_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire                       rsp_valid,
   input wire                       rsp_hit,
   input wire srht_pkg::region_type rsp_start_region,
   input wire srht_pkg::region_type rsp_end_region
);
   import srht_pkg::*;

   // every result traces back to a request a fixed latency earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without request");

   // shared outcode bit means trivially outside
   a_shared_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_start_region & rsp_end_region) != '0) |-> !rsp_hit)
      else $error("hit with shared outcode bit");

   // an endpoint inside means trivially hit
   a_inside_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_start_region & rsp_end_region) == '0) &&
      (rsp_start_region == '0 || rsp_end_region == '0) |-> rsp_hit)
      else $error("miss with endpoint inside");

   a_code_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_start_region[RC_LEFT_BIT] && rsp_start_region[RC_RIGHT_BIT]) &&
                    !(rsp_end_region[RC_UPPER_BIT] && rsp_end_region[RC_LOWER_BIT]))
      else $error("contradictory outcode");

endmodule

bind segment_rectangle_hit_test_core srht_checker u_srht_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_hit(rsp_hit),
   .rsp_start_region(rsp_start_region),
   .rsp_end_region(rsp_end_region)
);
`default_nettype wire

// ===== bench/tb_segment_rectangle_hit_test_core.sv =====
module tb_segment_rectangle_hit_test_core;
   import srht_pkg::*;

   localparam int CW = 16;
   localparam int CYCLE_LIMIT = 400000;

   // codes of a segment that spans the window exactly on one axis
   localparam region_type SPAN_X = region_type'((1 << RC_LEFT_BIT) | (1 << RC_RIGHT_BIT));
   localparam region_type SPAN_Y = region_type'((1 << RC_UPPER_BIT) | (1 << RC_LOWER_BIT));

   typedef struct {
      logic signed [CW-1:0] x1, y1, x2, y2;
   } segment_type;

   typedef struct {
      logic       hit;
      region_type start_region;
      region_type end_region;
   } hit_result_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [CW-1:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic csr_valid = 0;
   logic csr_ready;
   logic [1:0] csr_index = CSR_RECT_LEFT;
   logic signed [CW-1:0] csr_data = '0;
   logic rsp_valid, rsp_hit;
   region_type rsp_start_region, rsp_end_region;

   segment_rectangle_hit_test_core #(.COORD_BITS(CW)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_start_region(rsp_start_region), .rsp_end_region(rsp_end_region)
   );

   // predictor copy of the rectangle
   longint win_left = 32767, win_top = 32767, win_right = -32768, win_bottom = -32768;

   segment_type    pending_segments[$];
   hit_result_type expected_hits[$];
   bit             failed = 0;
   int             cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic region_type outcode(longint x, longint y);
      region_type c = '0;
      if (x < win_left) c[RC_LEFT_BIT] = 1'b1;
      else if (x > win_right) c[RC_RIGHT_BIT] = 1'b1;
      if (y < win_top) c[RC_UPPER_BIT] = 1'b1;
      else if (y > win_bottom) c[RC_LOWER_BIT] = 1'b1;
      return c;
   endfunction

   // base + a*m/d truncated toward zero
   function automatic longint crossing(longint base, longint a, longint m, longint d);
      longint q;
      if (d == 0) return base;
      q = ((a < 0 ? -a : a) * (m < 0 ? -m : m)) / (d < 0 ? -d : d);
      return (((a < 0) != (m < 0)) != (d < 0)) ? base - q : base + q;
   endfunction

   function automatic hit_result_type predict_hit(segment_type s);
      hit_result_type res;
      longint x1 = s.x1, y1 = s.y1, x2 = s.x2, y2 = s.y2;
      longint v;
      region_type c;
      res.start_region = outcode(x1, y1);
      res.end_region = outcode(x2, y2);
      c = res.start_region | res.end_region;
      res.hit = 1'b0;
      if ((res.start_region & res.end_region) != 0) begin
         res.hit = 1'b0;
      end else if (res.start_region == 0 || res.end_region == 0 || c == SPAN_X
                   || c == SPAN_Y) begin
         res.hit = 1'b1;
      end else begin
         if (!res.hit && c[RC_LEFT_BIT]) begin
            v = crossing(y1, win_left - x1, y2 - y1, x2 - x1);
            if (v >= win_top && v <= win_bottom) res.hit = 1'b1;
         end
         if (!res.hit && c[RC_RIGHT_BIT]) begin
            v = crossing(y1, win_right - x1, y2 - y1, x2 - x1);
            if (v >= win_top && v <= win_bottom) res.hit = 1'b1;
         end
         if (!res.hit && c[RC_UPPER_BIT]) begin
            v = crossing(x1, win_top - y1, x2 - x1, y2 - y1);
            if (v >= win_left && v <= win_right) res.hit = 1'b1;
         end
         if (!res.hit && c[RC_LOWER_BIT]) begin
            v = crossing(x1, win_bottom - y1, x2 - x1, y2 - y1);
            if (v >= win_left && v <= win_right) res.hit = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin : request_driver
      static int gap = 0;
      segment_type s;
      if (reset) begin
         start <= 1'b0;
         gap = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RECT_LEFT:   win_left = csr_data;
               CSR_RECT_TOP:    win_top = csr_data;
               CSR_RECT_RIGHT:  win_right = csr_data;
               CSR_RECT_BOTTOM: win_bottom = csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            s.x1 = req_start_x; s.y1 = req_start_y; s.x2 = req_end_x; s.y2 = req_end_y;
            expected_hits.push_back(predict_hit(s));
         end
         if (!(start && busy)) begin
            if (gap > 0) begin
               gap--;
               start <= 1'b0;
            end else if (pending_segments.size() > 0) begin
               s = pending_segments.pop_front();
               req_start_x <= s.x1; req_start_y <= s.y1;
               req_end_x <= s.x2; req_end_y <= s.y2;
               start <= 1'b1;
               gap = pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : result_monitor
      hit_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: unexpected result hit=%0b start=%h end=%h", $time, rsp_hit,
                     rsp_start_region, rsp_end_region);
            failed = 1;
         end else begin
            e = expected_hits.pop_front();
            if (rsp_hit !== e.hit) begin
               $display("%0t: hit expected %0b actual %0b", $time, e.hit, rsp_hit);
               failed = 1;
            end
            if (rsp_start_region !== e.start_region) begin
               $display("%0t: start_region expected %h actual %h", $time, e.start_region,
                        rsp_start_region);
               failed = 1;
            end
            if (rsp_end_region !== e.end_region) begin
               $display("%0t: end_region expected %h actual %h", $time, e.end_region,
                        rsp_end_region);
               failed = 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_segment_rectangle_hit_test_core NOT OK");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, longint value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CW-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(longint l, longint t, longint r, longint b);
      write_reg(CSR_RECT_LEFT, l);
      write_reg(CSR_RECT_TOP, t);
      write_reg(CSR_RECT_RIGHT, r);
      write_reg(CSR_RECT_BOTTOM, b);
   endtask

   task automatic add_segment(longint x1, longint y1, longint x2, longint y2);
      segment_type s;
      s.x1 = x1[CW-1:0]; s.y1 = y1[CW-1:0]; s.x2 = x2[CW-1:0]; s.y2 = y2[CW-1:0];
      pending_segments.push_back(s);
   endtask

   task automatic drain();
      while (pending_segments.size() > 0 || expected_hits.size() > 0 || start)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   function automatic longint clip(longint v);
      if (v < -32768) return -32768;
      if (v > 32767) return 32767;
      return v;
   endfunction

   // coordinate near the window span on one axis, or an extreme, or anything
   function automatic longint pick_coord(longint lo, longint hi);
      int mode = $urandom_range(0, 9);
      longint a = lo < hi ? lo : hi;
      longint b = lo < hi ? hi : lo;
      if (mode < 2) return longint'($signed(16'($urandom())));
      if (mode == 2) begin
         case ($urandom_range(0, 5))
            0: return -32768;
            1: return 32767;
            2: return clip(lo);
            3: return clip(hi);
            4: return clip(lo - 1);
            default: return clip(hi + 1);
         endcase
      end
      return clip(a - 64 + longint'($urandom_range(0, 32'(b - a + 128))));
   endfunction

   task automatic random_segments(int n);
      repeat (n)
         add_segment(pick_coord(win_left, win_right), pick_coord(win_top, win_bottom),
                     pick_coord(win_left, win_right), pick_coord(win_top, win_bottom));
   endtask

   task automatic directed_segments();
      add_segment(-32768, -32768, 32767, 32767);
      add_segment(32767, 32767, -32768, -32768);
      add_segment(-32768, 32767, 32767, -32768);
      add_segment(0, 0, 0, 0);
      add_segment(-100, -50, 200, 150);
      add_segment(-101, 0, 201, 0);
      add_segment(0, -51, 0, 151);
      add_segment(-300, 0, -200, 10);
      add_segment(-300, 0, 50, 400);
      add_segment(-150, 100, 50, 200);
      add_segment(-101, 140, -90, 160);
      add_segment(-200, -100, 300, 250);
      add_segment(250, -100, 150, -40);
      add_segment(210, 160, 190, 140);
      add_segment(-110, 160, 300, -60);
      add_segment(-32768, 0, -32768, 0);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty rectangle after reset
      directed_segments();
      drain();

      set_window(-100, -50, 200, 150);
      directed_segments();
      drain();
      random_segments(500);
      drain();

      set_window(-32768, -32768, 32767, 32767);
      directed_segments();
      random_segments(150);
      drain();

      set_window(7, -3, 7, -3);
      random_segments(200);
      drain();

      // not normalized: left above right
      set_window(300, 200, -300, -200);
      random_segments(150);
      drain();

      set_window(32767, 32767, 32767, 32767);
      random_segments(100);
      drain();

      set_window(-20000, 1000, 25000, 1200);
      random_segments(300);
      drain();

      set_window(-5, -5, 5, 5);
      random_segments(150);
      drain();

      if (!failed) begin
         $display("tb_segment_rectangle_hit_test_core OK");
      end else begin
         $display("tb_segment_rectangle_hit_test_core NOT OK");
      end
      $finish;
   end

endmodule

// ===== segment_rectangle_hit_test_core.f =====
hw/rtl/srht_pkg.sv
hw/rtl/segment_rectangle_hit_test_core.sv
hw/rtl/srht_checker.sv
bench/tb_segment_rectangle_hit_test_core.sv
